// ----- hw/rtl/wtr_pkg.sv -----
// Shared types, widths and segment tables for the wavelength to RGB block.
// Coefficient tables are built at elaboration from values in hundredths.
// No dependencies.
package wtr_pkg;

   localparam int COEF_FRAC_BITS = 14;
   localparam int COEF_W         = COEF_FRAC_BITS + 3;  // sign + two integer bits

   localparam int WL_W       = 10;
   localparam int T_W        = 16;
   localparam int TT_W       = 2 * T_W;
   localparam int D_W        = 7;   // widest segment spans 115 nm
   localparam int RECIP_W    = 13;  // largest reciprocal is 6554
   localparam int TPROD_W    = D_W + RECIP_W;
   localparam int PROD1_W    = COEF_W + T_W;
   localparam int PROD2_W    = COEF_W + TT_W;
   localparam int ACC_W      = COEF_W + TT_W + 2;
   localparam int OUT_W      = 8;
   localparam int OUT_SHIFT  = COEF_FRAC_BITS + 24;
   localparam int NUM_SEGS   = 10;
   localparam int SEG_W      = 4;
   localparam int NUM_CH     = 3;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = 2;
   localparam int QCNT_W     = 3;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = NUM_CH * OUT_W;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   localparam int unsigned T_ONE = 65536;
   localparam int unsigned T_MAX = T_ONE - 1;

   typedef logic signed [COEF_W-1:0] coef_type;

   typedef struct packed {
      logic             hit;
      logic [SEG_W-1:0] seg;
      logic [T_W-1:0]   t;
   } wtr_lane_type;

   typedef struct packed {
      wtr_lane_type [NUM_CH-1:0] lane;
   } wtr_entry_type;

   // round-half-up of |h|/100 in COEF_FRAC_BITS fraction bits, sign restored
   function automatic coef_type coef_q(input int h);
      longint mag;
      longint q;
      mag = (h < 0) ? -longint'(h) : longint'(h);
      q   = ((mag <<< COEF_FRAC_BITS) + 50) / 100;
      return coef_type'((h < 0) ? -q : q);
   endfunction

   localparam int unsigned SEG_CHAN [NUM_SEGS] = '{
      CH_RED, CH_RED, CH_RED, CH_RED, CH_RED,
      CH_GREEN, CH_GREEN, CH_GREEN,
      CH_BLUE, CH_BLUE};

   localparam int unsigned SEG_LO [NUM_SEGS] =
      '{400, 410, 545, 595, 650, 415, 475, 585, 400, 475};
   localparam int unsigned SEG_HI [NUM_SEGS] =
      '{410, 475, 595, 650, 700, 475, 590, 639, 475, 560};

   localparam int unsigned SEG_RECIP [NUM_SEGS] = '{
      (T_ONE + 10 / 2) / 10,
      (T_ONE + 65 / 2) / 65,
      (T_ONE + 50 / 2) / 50,
      (T_ONE + 55 / 2) / 55,
      (T_ONE + 50 / 2) / 50,
      (T_ONE + 60 / 2) / 60,
      (T_ONE + 115 / 2) / 115,
      (T_ONE + 54 / 2) / 54,
      (T_ONE + 75 / 2) / 75,
      (T_ONE + 85 / 2) / 85};

   localparam coef_type SEG_C0 [NUM_SEGS] = '{
      coef_q(0), coef_q(14), coef_q(0), coef_q(98), coef_q(65),
      coef_q(0), coef_q(80), coef_q(84), coef_q(0), coef_q(70)};
   localparam coef_type SEG_C1 [NUM_SEGS] = '{
      coef_q(33), coef_q(0), coef_q(198), coef_q(6), coef_q(-84),
      coef_q(0), coef_q(76), coef_q(-84), coef_q(220), coef_q(-100)};
   localparam coef_type SEG_C2 [NUM_SEGS] = '{
      coef_q(-20), coef_q(-13), coef_q(-100), coef_q(-40), coef_q(20),
      coef_q(80), coef_q(-80), coef_q(0), coef_q(-150), coef_q(30)};

endpackage

// ----- hw/rtl/wtr_front.sv -----
// Front end: finds the active segment of each channel and its position t.
// Depends on wtr_pkg.
module wtr_front (
   input  logic [wtr_pkg::WL_W-1:0] wavelength_nm,
   output wtr_pkg::wtr_entry_type   entry
);
   import wtr_pkg::*;

   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
      logic               hit;
      logic [SEG_W-1:0]   sel;
      logic [WL_W-1:0]    diff;
      logic [TPROD_W-1:0] prod;

      // walk from the back so the first listed segment wins
      always_comb begin
         hit = 1'b0;
         sel = '0;
         for (int i = NUM_SEGS - 1; i >= 0; i--) begin
            if (SEG_CHAN[i] == ch && wavelength_nm >= WL_W'(SEG_LO[i])
                && wavelength_nm < WL_W'(SEG_HI[i])) begin
               hit = 1'b1;
               sel = SEG_W'(i);
            end
         end
      end

      always_comb begin
         diff = wavelength_nm - WL_W'(SEG_LO[sel]);
         prod = diff[D_W-1:0] * RECIP_W'(SEG_RECIP[sel]);
         entry.lane[ch].hit = hit;
         entry.lane[ch].seg = sel;
         if (prod > TPROD_W'(T_MAX)) begin
            entry.lane[ch].t = '1;
         end else begin
            entry.lane[ch].t = prod[T_W-1:0];
         end
      end
   end

endmodule

// ----- hw/rtl/wtr_queue.sv -----
// Four-entry queue between the classifying front end and the evaluator.
// Depends on wtr_pkg.
module wtr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  wtr_pkg::wtr_entry_type  push_entry,
   input  logic                    pop,
   output wtr_pkg::wtr_entry_type  head_entry,
   output logic                    not_empty,
   output logic                    not_full
);
   import wtr_pkg::*;

   wtr_entry_type     entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign not_empty  = (count_ff != '0);
   assign not_full   = (count_ff != QCNT_W'(QDEPTH));
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/wtr_back.sv -----
// Back end: three-stage quadratic evaluator per channel, ending in an output register.
// Depends on wtr_pkg.
module wtr_back (
   input  logic                             clock,
   input  logic                             reset,
   input  wtr_pkg::wtr_entry_type           head_entry,
   input  logic                             head_valid,
   output logic                             head_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [wtr_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import wtr_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;
   logic [NUM_CH-1:0][OUT_W-1:0] out_ff;

   // each stage moves when it is empty or the one after it moves
   assign en3      = !v3_ff || rsp_tready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign head_pop = head_valid && en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= head_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
      wtr_lane_type               lane;
      coef_type                   c0_in, c1_in, c2_in;
      logic [TT_W-1:0]            tt_ff;
      logic signed [PROD1_W-1:0]  c1t_ff, c1t2_ff;
      coef_type                   c0_ff, c2_ff, c0_2_ff;
      logic signed [PROD2_W-1:0]  c2tt_ff;
      logic signed [ACC_W-1:0]    acc;
      logic [OUT_W-1:0]           sat;

      assign lane = head_entry.lane[ch];

      // a channel with no segment evaluates a zero polynomial
      always_comb begin
         c0_in = lane.hit ? SEG_C0[lane.seg] : '0;
         c1_in = lane.hit ? SEG_C1[lane.seg] : '0;
         c2_in = lane.hit ? SEG_C2[lane.seg] : '0;
      end

      always_ff @(posedge clock) begin
         if (en1) begin
            tt_ff  <= lane.t * lane.t;
            c1t_ff <= c1_in * $signed({1'b0, lane.t});
            c0_ff  <= c0_in;
            c2_ff  <= c2_in;
         end
         if (en2) begin
            c2tt_ff <= c2_ff * $signed({1'b0, tt_ff});
            c1t2_ff <= c1t_ff;
            c0_2_ff <= c0_ff;
         end
         if (en3) begin
            out_ff[ch] <= sat;
         end
      end

      // c0*2^32 + c1*t*2^16 + c2*t*t, then floor and clamp to 0..255
      always_comb begin
         acc = (ACC_W'(c0_2_ff) <<< TT_W) + (ACC_W'(c1t2_ff) <<< T_W)
               + ACC_W'(c2tt_ff);
         if (acc[ACC_W-1]) begin
            sat = '0;
         end else if (acc[ACC_W-2:OUT_SHIFT+OUT_W] != '0) begin
            sat = '1;
         end else begin
            sat = acc[OUT_SHIFT+OUT_W-1:OUT_SHIFT];
         end
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = out_ff;

endmodule

// ----- hw/rtl/wavelength_to_rgb.sv -----
// Wavelength to RGB converter: top level joining front end, queue and evaluator.
// Depends on wtr_pkg, wtr_front, wtr_queue, wtr_back.
//
// Maps a wavelength in whole nanometres to 8-bit red, green and blue values on
// piecewise quadratic curves; anything outside 400..699 nm comes out black. The
// block takes one item per clock while the output is not stalled. An accepted
// item passes through the queue, the evaluator's two multiplier stages and its
// output register before it shows on rsp_tvalid. A four-entry queue behind the
// segment classifier absorbs output stalls, so req_tready only falls after the
// result side has backed up through the evaluator and the queue.
module wavelength_to_rgb (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [wtr_pkg::REQ_DATA_W-1:0]   req_tdata,   // [9:0] wavelength_nm
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [wtr_pkg::RSP_DATA_W-1:0]   rsp_tdata    // [7:0] red, [15:8] green,
                                                          // [23:16] blue
);
   import wtr_pkg::*;

   wtr_entry_type front_entry;
   wtr_entry_type head_entry;
   logic          head_valid;
   logic          head_pop;
   logic          not_full;
   logic          push;

   assign req_tready = not_full;
   assign push       = req_tvalid && not_full;

   wtr_front u_front (
      .wavelength_nm (req_tdata[WL_W-1:0]),
      .entry         (front_entry)
   );

   wtr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (head_pop),
      .head_entry (head_entry),
      .not_empty  (head_valid),
      .not_full   (not_full)
   );

   wtr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- hw/rtl/wtr_checker.sv -----
// Port-level checks for wavelength_to_rgb, attached by a bind.
// Depends on wtr_pkg.
module wtr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [wtr_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import wtr_pkg::*;

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   // a stalled result keeps its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // the queue can only fill up behind a full, stalled evaluator
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // reset empties the pipe and the queue
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

endmodule

bind wavelength_to_rgb wtr_checker u_wtr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/tb_wavelength_to_rgb.sv -----
// Self-checking testbench for wavelength_to_rgb: directed table, then random wavelengths,
// with random gaps on both stream sides, checked against a fixed-point color predictor.
// Depends on wtr_pkg and the wavelength_to_rgb RTL.
`timescale 1ns / 100ps

module tb_wavelength_to_rgb;
   import wtr_pkg::*;

   localparam int NUM_RANDOM  = 850;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AT     = 200;   // items accepted before the long output hold-off
   localparam int HOLD_CYCLES = 300;
   localparam int NUM_BANDS   = 10;
   localparam int NUM_DIR     = 24;

   typedef struct packed {
      logic [OUT_W-1:0] blue;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] red;
   } rgb_type;

   typedef struct packed {
      logic [WL_W-1:0] wl;
      logic            known;   // expected color typed in below
      rgb_type         rgb;
   } dir_row_type;

   // curve bands: channel, span [lo, hi) in nm, quadratic coefficients in hundredths
   localparam int BAND_CH [NUM_BANDS] = '{CH_RED, CH_RED, CH_RED, CH_RED, CH_RED,
                                          CH_GREEN, CH_GREEN, CH_GREEN, CH_BLUE, CH_BLUE};
   localparam int BAND_LO [NUM_BANDS] = '{400, 410, 545, 595, 650, 415, 475, 585, 400, 475};
   localparam int BAND_HI [NUM_BANDS] = '{410, 475, 595, 650, 700, 475, 590, 639, 475, 560};
   localparam int BAND_K0 [NUM_BANDS] = '{0, 14, 0, 98, 65, 0, 80, 84, 0, 70};
   localparam int BAND_K1 [NUM_BANDS] = '{33, 0, 198, 6, -84, 0, 76, -84, 220, -100};
   localparam int BAND_K2 [NUM_BANDS] = '{-20, -13, -100, -40, 20, 80, -80, 0, -150, 30};

   // out of range and band starts with a zero constant term read off as black
   localparam dir_row_type DIR_ROWS [NUM_DIR] = '{
      '{10'd0,    1'b1, 24'h000000},
      '{10'd1023, 1'b1, 24'h000000},
      '{10'd399,  1'b1, 24'h000000},
      '{10'd700,  1'b1, 24'h000000},
      '{10'd512,  1'b0, 24'h000000},
      '{10'd400,  1'b1, 24'h000000},
      '{10'd682,  1'b0, 24'h000000},
      '{10'd409,  1'b0, 24'h000000},
      '{10'd410,  1'b0, 24'h000000},
      '{10'd415,  1'b0, 24'h000000},
      '{10'd474,  1'b0, 24'h000000},
      '{10'd475,  1'b0, 24'h000000},
      '{10'd544,  1'b0, 24'h000000},
      '{10'd545,  1'b0, 24'h000000},
      '{10'd560,  1'b0, 24'h000000},
      '{10'd584,  1'b0, 24'h000000},
      '{10'd585,  1'b0, 24'h000000},
      '{10'd589,  1'b0, 24'h000000},
      '{10'd590,  1'b0, 24'h000000},
      '{10'd595,  1'b0, 24'h000000},
      '{10'd638,  1'b0, 24'h000000},
      '{10'd639,  1'b0, 24'h000000},
      '{10'd650,  1'b0, 24'h000000},
      '{10'd699,  1'b0, 24'h000000}};

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [9:0] wavelength_nm
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [7:0] red, [15:8] green, [23:16] blue

   rgb_type expected_colors [$];
   int      mismatches = 0;
   int      n_accepted = 0;

   wavelength_to_rgb dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint quant_coef(input int h);
      longint mag;
      longint q;
      mag = (h < 0) ? -longint'(h) : longint'(h);
      q   = ((mag << COEF_FRAC_BITS) + 50) / 100;
      return (h < 0) ? -q : q;
   endfunction

   // first band of a channel that covers wl wins; uncovered channels stay black
   function automatic rgb_type predict_color(input logic [WL_W-1:0] wl);
      rgb_type c;
      bit      taken [NUM_CH];
      longint  span;
      longint  recip;
      longint  tpos;
      longint  acc;
      longint  v;
      int      ch;
      c     = '0;
      taken = '{default: 1'b0};
      for (int b = 0; b < NUM_BANDS; b++) begin
         ch = BAND_CH[b];
         if (!taken[ch] && int'(wl) >= BAND_LO[b] && int'(wl) < BAND_HI[b]) begin
            taken[ch] = 1'b1;
            span  = BAND_HI[b] - BAND_LO[b];
            recip = (65536 + span / 2) / span;
            tpos  = (longint'(wl) - BAND_LO[b]) * recip;
            if (tpos > 65535) tpos = 65535;
            acc = (quant_coef(BAND_K0[b]) <<< 32)
                + quant_coef(BAND_K1[b]) * tpos * 65536
                + quant_coef(BAND_K2[b]) * tpos * tpos;
            if (acc <= 0) begin
               v = 0;
            end else begin
               v = acc >>> (COEF_FRAC_BITS + 24);
               if (v > 255) v = 255;
            end
            unique case (ch)
               CH_RED:   c.red   = v[OUT_W-1:0];
               CH_GREEN: c.green = v[OUT_W-1:0];
               default:  c.blue  = v[OUT_W-1:0];
            endcase
         end
      end
      return c;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // offer one item and hold it until accepted; valid stays high if the next follows at once
   task automatic send_wavelength(input logic [WL_W-1:0] wl, input int gap,
                                  input bit known, input rgb_type known_rgb);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-WL_W){1'b0}}, wl};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_colors.push_back(known ? known_rgb : predict_color(wl));
      n_accepted++;
   endtask

   task automatic check_color(input rgb_type got);
      rgb_type want;
      if (expected_colors.size() == 0) begin
         if (mismatches < 10) $display("unexpected item: %h", got);
         mismatches++;
      end else begin
         want = expected_colors.pop_front();
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
         begin
            if (mismatches < 10)
               $display("color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        want.red, want.green, want.blue, got.red, got.green, got.blue);
            mismatches++;
         end
      end
   endtask

   // stimulus
   initial begin
      logic [WL_W-1:0] wl;
      bit              burst;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_DIR; i++)
         send_wavelength(DIR_ROWS[i].wl, pick_gap(), DIR_ROWS[i].known, DIR_ROWS[i].rgb);
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if ($urandom_range(0, 4) == 0) wl = WL_W'($urandom_range(0, 1023));
         else                           wl = WL_W'($urandom_range(395, 705));
         burst = ((i / 50) % 5) == 4;
         send_wavelength(wl, burst ? 0 : pick_gap(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_wavelength_to_rgb: done, clean");
      end else begin
         $display("tb_wavelength_to_rgb: done, errors");
      end
      $finish;
   end

   // result side: check accepted items, then choose next tready
   initial begin
      int rx_cycles;
      int stall_left;
      int hold_left;
      bit hold_done;
      rx_cycles  = 0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      forever begin
         @(posedge clock);
         rx_cycles++;
         if (!reset && rsp_tvalid && rsp_tready) check_color(rgb_type'(rsp_tdata));
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && n_accepted >= HOLD_AT) begin
            // long hold-off: the sender keeps offering until the block backs up
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (((rx_cycles / 256) % 5) == 2) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left = pick_gap();
            if (stall_left == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               stall_left--;
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_wavelength_to_rgb: done, errors");
      $finish;
   end

endmodule
